>>> rtl/audio_buffer_rate_pi_controller_defines.svh
// Assertion macros shared by the audio buffer rate controller RTL.
// Depends on nothing; the including module provides clk and rst.
`ifndef AUDIO_BUFFER_RATE_PI_CONTROLLER_DEFINES_SVH
`define AUDIO_BUFFER_RATE_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define ABRPC_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("abrpc same-cycle check failed");

// Next-cycle implication, inactive during reset.
`define ABRPC_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("abrpc next-cycle check failed");

`endif

>>> rtl/abrpc_pkg.sv
// Shared types, constants and elaboration-time functions of the rate controller.
// Used by the controller, the datapath and the top level.
package abrpc_pkg;

  localparam int FILL_WIDTH_DEFAULT  = 16;
  localparam int TABLE_DEPTH_DEFAULT = 256;
  localparam int FRAC_BITS_DEFAULT   = 8;

  localparam logic [15:0] CAPACITY_RESET  = 16'd16384;
  localparam logic [14:0] MAX_CORR_RESET  = 15'd328;
  localparam logic [7:0]  SMOOTHING_RESET = 8'd4;
  localparam logic [7:0]  INTEGRAL_RESET  = 8'd8;

  localparam logic [16:0] WEIGHT_ONE = 17'h10000;
  localparam logic [16:0] ERR_ONE    = 17'h10000;

  typedef enum logic [1:0] {
    REG_CAPACITY  = 2'd0,
    REG_MAX_CORR  = 2'd1,
    REG_SMOOTHING = 2'd2,
    REG_INTEGRAL  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] capacity;
    logic [14:0] max_corr;
    logic [7:0]  smoothing;
    logic [7:0]  integral;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ZERO,
    OP_SEED,
    OP_WINDOW,
    OP_IDX_START,
    OP_WEIGHT,
    OP_AVG_MUL,
    OP_AVG_ADD,
    OP_ERR_START,
    OP_ERR_LOAD,
    OP_MUL_ERR,
    OP_MUL_CARRY,
    OP_STEP_START,
    OP_CAND,
    OP_DECIDE,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic restart;
    logic cap_zero;
    logic seeded;
    logic div_busy;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_IDX_START,
    ST_IDX_DIV,
    ST_WEIGHT,
    ST_AVG_MUL,
    ST_AVG_ADD,
    ST_ERR_START,
    ST_ERR_DIV,
    ST_ERR_LOAD,
    ST_MUL_ERR,
    ST_MUL_CARRY,
    ST_STEP_START,
    ST_STEP_DIV,
    ST_CAND,
    ST_DECIDE,
    ST_RESULT,
    ST_EMIT
  } state_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Shift-subtract division, elaboration only.
  function automatic longint unsigned wt_udiv(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-8/depth) in Q32 from a truncated Taylor series.
  function automatic longint unsigned wt_ratio(input int depth);
    longint unsigned t;
    longint unsigned r;
    t = 64'd1 << 32;
    r = t;
    for (int k = 1; k <= 24; k++) begin
      t = wt_udiv(t * 64'd8, 64'(depth) * 64'(k));
      if (k % 2 == 1) r = r - t;
      else r = r + t;
    end
    return r;
  endfunction

  // Weight table entry: 1 - ratio^idx in Q16.
  function automatic int wt_entry(input longint unsigned ratio, input int idx);
    longint unsigned p;
    p = 64'd1 << 32;
    for (int i = 0; i < idx; i++) begin
      p = (p * ratio + (64'd1 << 31)) >> 32;
    end
    return int'(64'd65536 - ((p + 64'd32768) >> 16));
  endfunction

endpackage

>>> rtl/audio_buffer_rate_pi_controller.sv
// Top level of the audio buffer rate controller: ports, config registers, output stage.
// Depends on abrpc_pkg, abrpc_ctrl, abrpc_dp and the assertion macro header.
//
// Each input beat reports the audio buffer fill and the frames just delivered;
// the block answers with one signed Q16 rate correction (positive stretches
// audio), clamped to the configured correction limit. A beat with tuser set
// clears the fill average and the integral term and produces no output beat.
// With capacity 0 the answer is 0 and no state moves. Items are handled one at
// a time: a restart or a zero-capacity item runs no division, the first item
// after reset or restart two and every later item three, all on the one shared
// bit-serial divider (quotient width 46 at the default parameters), and an
// item may also wait for the output register to free. That divider, run for
// the table index, the normalized error and the integral step, sets the rate.
// A finished result waits in the output register while the next beat is taken
// in. Input is closed during reset. Configuration is written through
// cfg_we/cfg_index/cfg_data by the user only while idle; the block does not check.
`include "audio_buffer_rate_pi_controller_defines.svh"

module audio_buffer_rate_pi_controller #(
  parameter int FILL_WIDTH  = abrpc_pkg::FILL_WIDTH_DEFAULT,
  parameter int TABLE_DEPTH = abrpc_pkg::TABLE_DEPTH_DEFAULT,
  parameter int FRAC_BITS   = abrpc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] used_bytes, [27:16] frames_this_call
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] correction (signed)
);

  import abrpc_pkg::*;

  cfg_t               cfg;
  dp_op_t             op;
  dp_status_t         status;
  logic signed [15:0] result;
  logic               out_load;
  logic               out_free;
  logic               out_in_limit;

  // Configuration registers; write them only while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity  <= CAPACITY_RESET;
      cfg.max_corr  <= MAX_CORR_RESET;
      cfg.smoothing <= SMOOTHING_RESET;
      cfg.integral  <= INTEGRAL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CAPACITY:  cfg.capacity  <= cfg_data;
        REG_MAX_CORR:  cfg.max_corr  <= cfg_data[14:0];
        REG_SMOOTHING: cfg.smoothing <= cfg_data[7:0];
        REG_INTEGRAL:  cfg.integral  <= cfg_data[7:0];
        default:       cfg.capacity  <= cfg.capacity;
      endcase
    end
  end

  abrpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .op       (op)
  );

  abrpc_dp #(
    .FILL_WIDTH  (FILL_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .cfg        (cfg),
    .in_restart (s_axis_tuser),
    .in_used    (s_axis_tdata[15:0]),
    .in_frames  (s_axis_tdata[27:16]),
    .status     (status),
    .result     (result)
  );

  // Output register: hold the beat until the sink takes it.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= result;
  end

  assign out_in_limit = ($signed(m_axis_tdata) <= $signed({1'b0, cfg.max_corr})) &&
                        ($signed(m_axis_tdata) >= -$signed({1'b0, cfg.max_corr}));

  // An accepted beat keeps the input closed while it is worked on.
  `ABRPC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A new result never overwrites a beat still waiting.
  `ABRPC_ASSERT_NOW(a_load_when_free, out_load, !m_axis_tvalid || m_axis_tready)
  // Every correction lies within the configured limit.
  `ABRPC_ASSERT_NOW(a_within_limit, m_axis_tvalid, out_in_limit)

endmodule

>>> rtl/abrpc_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; instantiated by the datapath.
module abrpc_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CntW-1:0]  count;
  logic [DEN_W:0]   trial;

  assign trial = {rem, quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CntW'(NUM_W);
      rem   <= '0;
      dvs   <= den;
      quot  <= num;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= DEN_W'(trial - {1'b0, dvs});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CntW'(1)) busy <= 1'b0;
    end
  end

endmodule

>>> rtl/abrpc_dp.sv
// Datapath of the rate controller: state, weight table, multipliers, divider.
// Depends on abrpc_pkg and abrpc_div; driven by op codes from abrpc_ctrl.
module abrpc_dp #(
  parameter int FILL_WIDTH  = abrpc_pkg::FILL_WIDTH_DEFAULT,
  parameter int TABLE_DEPTH = abrpc_pkg::TABLE_DEPTH_DEFAULT,
  parameter int FRAC_BITS   = abrpc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  abrpc_pkg::dp_op_t      op,
  input  abrpc_pkg::cfg_t        cfg,
  input  logic                   in_restart,
  input  logic [15:0]            in_used,
  input  logic [11:0]            in_frames,
  output abrpc_pkg::dp_status_t  status,
  output logic signed [15:0]     result
);

  import abrpc_pkg::*;

  localparam int AW       = FILL_WIDTH + FRAC_BITS;
  localparam int CapfW    = 16 + FRAC_BITS;
  localparam int CarW     = 14;
  localparam int WinW     = 24;
  localparam int IdxW     = $clog2(TABLE_DEPTH);
  localparam int DepW     = IdxW + 1;
  localparam int IdxNumW  = max2(CarW + 1 + DepW, WinW + 3) + 1;
  localparam int IdxDenW  = WinW + 4;
  localparam int DiffW    = max2(AW + 1, CapfW) + 1;
  localparam int ErrNumW  = DiffW + 16;
  localparam int StepNumW = 46;
  localparam int StepDenW = 40;
  localparam int DivNW    = max2(max2(IdxNumW, ErrNumW), StepNumW);
  localparam int DivDW    = max2(max2(IdxDenW, CapfW), StepDenW);
  localparam int PW       = AW + 1 + 18;
  localparam int SW       = DivNW + 1;
  localparam logic [31:0] FillMax = 32'((64'd1 << FILL_WIDTH) - 64'd1);
  localparam longint unsigned Ratio = wt_ratio(TABLE_DEPTH);

  logic [15:0] rom [TABLE_DEPTH];
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = 16'(wt_entry(Ratio, g));
  end

  logic                   restart_q;
  logic [FILL_WIDTH-1:0]  used_q;
  logic [CarW-1:0]        carried_q;
  logic [AW-1:0]          avg;
  logic                   seeded;
  logic signed [16:0]     standing;
  logic [WinW-1:0]        win;
  logic [16:0]            w;
  logic signed [PW-1:0]   avg_prod;
  logic                   err_neg;
  logic signed [17:0]     err;
  logic signed [33:0]     pm;
  logic signed [48:0]     sm;
  logic [23:0]            id;
  logic signed [16:0]     prop;
  logic                   step_neg;
  logic signed [16:0]     cand;

  logic             div_start;
  logic [DivNW-1:0] div_num;
  logic [DivDW-1:0] div_den;
  logic             div_busy;
  logic [DivNW-1:0] quot;

  abrpc_div #(.NUM_W(DivNW), .DEN_W(DivDW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  logic [31:0]             used_sat;
  logic [7:0]              smooth_eff;
  logic [7:0]              integ_eff;
  logic [CapfW-1:0]        capf;
  logic [IdxNumW-1:0]      idx_num;
  logic signed [DiffW-1:0] err_num;
  logic [DiffW-1:0]        err_mag;
  logic [ErrNumW-1:0]      err_div_num;
  logic [48:0]             sm_mag;
  logic [16:0]             err_clip;
  logic signed [17:0]      err_val;
  logic signed [AW:0]      diff;
  logic [PW-1:0]           avg_mag;
  logic [PW-1:0]           avg_rnd;
  logic signed [AW+1:0]    avg_delta;
  logic [33:0]             pm_mag;
  logic [33:0]             pm_rnd;
  logic signed [16:0]      prop_val;
  logic signed [SW-1:0]    step;
  logic signed [SW-1:0]    cand_wide;
  logic signed [SW-1:0]    mx_wide;
  logic signed [17:0]      total;
  logic signed [17:0]      total_abs;
  logic signed [17:0]      cand_abs;
  logic signed [17:0]      stand_abs;
  logic signed [17:0]      out_sum;
  logic signed [17:0]      mx18;

  always_comb begin
    used_sat   = (32'(in_used) > FillMax) ? FillMax : 32'(in_used);
    smooth_eff = (cfg.smoothing == 8'd0) ? 8'd1 : cfg.smoothing;
    integ_eff  = (cfg.integral == 8'd0) ? 8'd1 : cfg.integral;
    capf       = {cfg.capacity, FRAC_BITS'(0)};
    idx_num    = IdxNumW'({carried_q, 1'b0}) * IdxNumW'(TABLE_DEPTH)
               + IdxNumW'({win, 3'b000});
    err_num    = DiffW'({avg, 1'b0}) - DiffW'(capf);
    err_mag    = err_num[DiffW-1] ? DiffW'(-err_num) : DiffW'(err_num);
    err_div_num = ErrNumW'({err_mag, 16'h0000}) + ErrNumW'(capf >> 1);
    sm_mag     = sm[48] ? 49'(-sm) : 49'(sm);

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (op)
      OP_IDX_START: begin
        div_start = 1'b1;
        div_num   = DivNW'(idx_num);
        div_den   = DivDW'({win, 4'h0});
      end
      OP_ERR_START: begin
        div_start = 1'b1;
        div_num   = DivNW'(err_div_num);
        div_den   = DivDW'(capf);
      end
      OP_STEP_START: begin
        div_start = 1'b1;
        div_num   = DivNW'(sm_mag) + DivNW'({id, 15'h0000});
        div_den   = DivDW'({id, 16'h0000});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase

    // error magnitude saturates at one
    err_clip = (quot > DivNW'(ERR_ONE)) ? ERR_ONE : quot[16:0];
    err_val  = err_neg ? -$signed({1'b0, err_clip}) : $signed({1'b0, err_clip});

    diff      = $signed({1'b0, used_q, FRAC_BITS'(0)}) - $signed({1'b0, avg});
    avg_mag   = avg_prod[PW-1] ? PW'(-avg_prod) : PW'(avg_prod);
    avg_rnd   = (avg_mag + PW'(32768)) >> 16;
    avg_delta = avg_prod[PW-1] ? -$signed((AW+2)'(avg_rnd)) : $signed((AW+2)'(avg_rnd));

    pm_mag   = pm[33] ? 34'(-pm) : 34'(pm);
    pm_rnd   = (pm_mag + 34'd32768) >> 16;
    prop_val = pm[33] ? $signed(17'(pm_rnd)) : -$signed(17'(pm_rnd));

    step      = step_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    mx_wide   = $signed(SW'({1'b0, cfg.max_corr}));
    cand_wide = SW'(standing) - step;

    mx18      = $signed({3'b000, cfg.max_corr});
    total     = 18'(prop) + 18'(cand);
    total_abs = total[17] ? -total : total;
    cand_abs  = cand[16] ? -18'(cand) : 18'(cand);
    stand_abs = standing[16] ? -18'(standing) : 18'(standing);
    out_sum   = 18'(prop) + 18'(standing);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg      <= '0;
      seeded   <= 1'b0;
      standing <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          restart_q <= in_restart;
          used_q    <= FILL_WIDTH'(used_sat);
          carried_q <= {in_frames, 2'b00};
        end
        OP_CLEAR: begin
          avg      <= '0;
          seeded   <= 1'b0;
          standing <= '0;
        end
        OP_ZERO:   result <= '0;
        OP_SEED: begin
          avg    <= {used_q, FRAC_BITS'(0)};
          seeded <= 1'b1;
        end
        OP_WINDOW: win <= WinW'(smooth_eff) * WinW'(cfg.capacity);
        OP_WEIGHT: begin
          if (quot >= DivNW'(TABLE_DEPTH)) w <= WEIGHT_ONE;
          else w <= {1'b0, rom[quot[IdxW-1:0]]};
        end
        OP_AVG_MUL:   avg_prod <= PW'(diff) * PW'($signed({1'b0, w}));
        OP_AVG_ADD:   avg <= AW'($signed({2'b00, avg}) + avg_delta);
        OP_ERR_START: err_neg <= err_num[DiffW-1];
        OP_ERR_LOAD:  err <= err_val;
        OP_MUL_ERR: begin
          pm <= 34'($signed({1'b0, cfg.max_corr})) * 34'(err);
          id <= 24'(integ_eff) * 24'(cfg.capacity);
        end
        OP_MUL_CARRY: begin
          sm   <= 49'(pm) * 49'($signed({1'b0, carried_q}));
          prop <= prop_val;
        end
        OP_STEP_START: step_neg <= sm[48];
        OP_CAND: begin
          if (cand_wide > mx_wide) cand <= 17'(mx_wide);
          else if (cand_wide < -mx_wide) cand <= 17'(-mx_wide);
          else cand <= 17'(cand_wide);
        end
        OP_DECIDE: begin
          // hold the integral while saturated unless it shrinks
          if (total_abs < mx18 || cand_abs < stand_abs) standing <= cand;
        end
        OP_RESULT: begin
          if (out_sum > mx18) result <= 16'(mx18);
          else if (out_sum < -mx18) result <= 16'(-mx18);
          else result <= 16'(out_sum);
        end
        default: begin
          avg <= avg;
        end
      endcase
    end
  end

  assign status = '{restart:  restart_q,
                    cap_zero: (cfg.capacity == 16'd0),
                    seeded:   seeded,
                    div_busy: div_busy};

endmodule

>>> rtl/abrpc_ctrl.sv
// Sequencer of the rate controller: steps the datapath through one update.
// Depends on abrpc_pkg.
module abrpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_free,
  output logic                  out_load,
  input  abrpc_pkg::dp_status_t status,
  output abrpc_pkg::dp_op_t     op
);

  import abrpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          op         = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.restart) begin
          op         = OP_CLEAR;
          state_next = ST_IDLE;
        end else if (status.cap_zero) begin
          op         = OP_ZERO;
          state_next = ST_EMIT;
        end else if (!status.seeded) begin
          op         = OP_SEED;
          state_next = ST_ERR_START;
        end else begin
          op         = OP_WINDOW;
          state_next = ST_IDX_START;
        end
      end
      ST_IDX_START: begin
        op         = OP_IDX_START;
        state_next = ST_IDX_DIV;
      end
      ST_IDX_DIV:   if (!status.div_busy) state_next = ST_WEIGHT;
      ST_WEIGHT: begin
        op         = OP_WEIGHT;
        state_next = ST_AVG_MUL;
      end
      ST_AVG_MUL: begin
        op         = OP_AVG_MUL;
        state_next = ST_AVG_ADD;
      end
      ST_AVG_ADD: begin
        op         = OP_AVG_ADD;
        state_next = ST_ERR_START;
      end
      ST_ERR_START: begin
        op         = OP_ERR_START;
        state_next = ST_ERR_DIV;
      end
      ST_ERR_DIV:   if (!status.div_busy) state_next = ST_ERR_LOAD;
      ST_ERR_LOAD: begin
        op         = OP_ERR_LOAD;
        state_next = ST_MUL_ERR;
      end
      ST_MUL_ERR: begin
        op         = OP_MUL_ERR;
        state_next = ST_MUL_CARRY;
      end
      ST_MUL_CARRY: begin
        op         = OP_MUL_CARRY;
        state_next = ST_STEP_START;
      end
      ST_STEP_START: begin
        op         = OP_STEP_START;
        state_next = ST_STEP_DIV;
      end
      ST_STEP_DIV:  if (!status.div_busy) state_next = ST_CAND;
      ST_CAND: begin
        op         = OP_CAND;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        op         = OP_DECIDE;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        op         = OP_RESULT;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> bench/tb_audio_buffer_rate_pi_controller.sv
// Self-checking bench for the audio buffer rate PI controller.
// Depends on abrpc_pkg and audio_buffer_rate_pi_controller; predicts every correction beat.
module tb_audio_buffer_rate_pi_controller;
  import abrpc_pkg::*;

  localparam int DEPTH = 256;
  localparam int FRAC = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  audio_buffer_rate_pi_controller dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: configuration, smoothed fill, integral term.
  longint unsigned weight_lut [DEPTH];
  longint unsigned cap_r, maxc_r, smooth_r, integ_r;
  longint unsigned fill_avg;
  bit fill_seeded;
  longint standing;

  logic [15:0] corr_queue [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit hold_off = 1'b0;
  bit out_wait_enable = 1'b1;

  function automatic longint round_div(longint num, longint den);
    longint unsigned m, q;
    m = (num < 0) ? longint'(-num) : num;
    q = (m + longint'(den) / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic build_weights();
    longint unsigned t, r, p;
    t = 64'd1 << 32;
    r = t;
    p = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      t = (t * 8) / (DEPTH * k);
      if (k % 2) r -= t;
      else r += t;
    end
    for (int i = 0; i < DEPTH; i++) begin
      weight_lut[i] = 65536 - ((p + 32768) >> 16);
      p = (p * r + (64'd1 << 31)) >> 32;
    end
  endtask

  // Advance the predicted state by one measurement; push the correction if any.
  task automatic predict_correction(bit restart, longint unsigned used, longint unsigned frames);
    longint unsigned carried, sm, ig, window, idx;
    longint mx, w, diff, capf, num, err, prop, stp, cand;
    carried = frames * 4;
    sm = smooth_r ? smooth_r : 1;
    ig = integ_r ? integ_r : 1;
    mx = maxc_r;
    if (restart) begin
      fill_avg = 0;
      fill_seeded = 0;
      standing = 0;
      return;
    end
    if (cap_r == 0) begin
      corr_queue.push_back(16'd0);
      return;
    end
    if (!fill_seeded) begin
      fill_avg = used << FRAC;
      fill_seeded = 1;
    end else begin
      window = sm * cap_r;
      idx = (2 * carried * DEPTH + 8 * window) / (16 * window);
      w = (idx >= DEPTH) ? 65536 : longint'(weight_lut[idx]);
      diff = longint'(used << FRAC) - longint'(fill_avg);
      fill_avg = longint'(fill_avg) + round_div(diff * w, 65536);
    end
    capf = cap_r << FRAC;
    num = 2 * longint'(fill_avg) - capf;
    err = clip(round_div(num * 65536, capf), -65536, 65536);
    prop = round_div(-mx * err, 65536);
    stp = round_div(mx * err * longint'(carried), longint'(ig * cap_r * 65536));
    cand = clip(standing - stp, -mx, mx);
    if (magn(prop + cand) < mx || magn(cand) < magn(standing)) standing = cand;
    corr_queue.push_back(16'(clip(prop + standing, -mx, mx)));
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAPACITY: cap_r = value;
      REG_MAX_CORR: maxc_r = value[14:0];
      REG_SMOOTHING: smooth_r = value[7:0];
      default: integ_r = value[7:0];
    endcase
  endtask

  // Drive one input beat after the given gap; hold until accepted.
  task automatic send_beat(bit restart, logic [15:0] used, logic [11:0] frames, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= restart;
    s_axis_tdata <= {4'd0, frames, used};
    do @(posedge clk); while (!s_axis_tready);
    predict_correction(restart, used, frames);
  endtask

  // Drop valid, drain the expected store, then let a restart or a late item settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (corr_queue.size() != 0 && !timed_out) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Directed rows: restart, used, frames, and a fixed answer where obvious.
  typedef struct {
    bit restart;
    logic [15:0] used;
    logic [11:0] frames;
    bit has_fixed;
    logic [15:0] fixed_corr;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{1'b0, 16'd8192, 12'd256, 1'b1, 16'd0},       // seeded at half capacity
    '{1'b0, 16'd0, 12'd0, 1'b0, 16'd0},            // zero carried holds average
    '{1'b0, 16'd65535, 12'd4095, 1'b0, 16'd0},
    '{1'b0, 16'd65535, 12'd4095, 1'b0, 16'd0},
    '{1'b1, 16'd1234, 12'd55, 1'b0, 16'd0},        // restart clears state
    '{1'b0, 16'd0, 12'd100, 1'b1, 16'd328},        // seeded empty: full positive
    '{1'b0, 16'd0, 12'd4095, 1'b0, 16'd0},
    '{1'b1, 16'd0, 12'd0, 1'b0, 16'd0},
    '{1'b0, 16'd65535, 12'd1, 1'b1, -16'sd328},    // seeded far over: full negative
    '{1'b0, 16'd16384, 12'd2048, 1'b0, 16'd0},
    '{1'b0, 16'd4096, 12'd1024, 1'b0, 16'd0},
    '{1'b0, 16'd12000, 12'd3000, 1'b0, 16'd0}
  };

  // Compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (corr_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected correction beat %0d", $signed(m_axis_tdata));
      end else begin
        want = corr_queue.pop_front();
        if (want !== m_axis_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("correction mismatch: expected %0d got %0d", $signed(want),
                     $signed(m_axis_tdata));
        end
      end
    end
  end

  // Output side: random stalls per beat, or a long hold-off on request.
  initial begin
    int w;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      w = out_wait_enable ? $urandom_range(0, 14) : 0;
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w - 1) @(posedge clk);
        @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      m_axis_tready <= 1'b0;
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL audio_buffer_rate_pi_controller");
      $finish;
    end
  end

  initial begin
    int gap;
    logic [15:0] caps [6] = '{16'd16384, 16'd1, 16'd65535, 16'd0, 16'd3000, 16'd16384};
    logic [15:0] maxs [6] = '{16'd328, 16'd32767, 16'd0, 16'd1000, 16'd328, 16'd5000};
    logic [15:0] smos [6] = '{16'd4, 16'd1, 16'd255, 16'd0, 16'd2, 16'd16};
    logic [15:0] ints [6] = '{16'd8, 16'd255, 16'd1, 16'd0, 16'd3, 16'd32};
    cap_r = CAPACITY_RESET;
    maxc_r = MAX_CORR_RESET;
    smooth_r = SMOOTHING_RESET;
    integ_r = INTEGRAL_RESET;
    fill_avg = 0;
    fill_seeded = 0;
    standing = 0;
    build_weights();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Directed table at reset configuration.
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].restart, dir_rows[i].used, dir_rows[i].frames, $urandom_range(0, 14));
      if (dir_rows[i].has_fixed && corr_queue.size() != 0 &&
          corr_queue[$] !== dir_rows[i].fixed_corr) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: predictor disagrees with table", i);
      end
    end
    wait_drained();

    // Random phases across register settings; each phase starts with a restart.
    foreach (caps[p]) begin
      write_reg(REG_CAPACITY, caps[p]);
      write_reg(REG_MAX_CORR, maxs[p]);
      write_reg(REG_SMOOTHING, smos[p]);
      write_reg(REG_INTEGRAL, ints[p]);
      out_wait_enable = (p != 4);
      if (p == 1) hold_off = 1'b1;
      send_beat(1'b1, 16'($urandom), 12'($urandom), 0);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        logic [15:0] used;
        gap = (p == 4) ? 0 : $urandom_range(0, 14);
        // Keep fills mostly between zero and the configured capacity, with full-range noise.
        if ($urandom_range(0, 3) == 0 || caps[p] == 0) used = 16'($urandom);
        else used = 16'($urandom_range(0, caps[p]));
        send_beat($urandom_range(0, 40) == 0, used,
                  ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600)),
                  gap);
      end
      wait_drained();
    end

    if (mismatches == 0 && corr_queue.size() == 0) begin
      $display("PASS audio_buffer_rate_pi_controller");
    end else begin
      $display("FAIL audio_buffer_rate_pi_controller");
    end
    $finish;
  end
endmodule
